### design/twsm_pkg.sv
package twsm_pkg;

   localparam int BYTE_BITS = 8;
   localparam int IDX_BITS  = $clog2(BYTE_BITS) + 1;
   localparam int REQ_BITS  = 24;
   localparam int RSP_BITS  = 16;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   localparam logic [7:0] CMD_WRITE_SET = 8'b1000_0000;
   localparam logic [7:0] CMD_WRITE_CLR = 8'b1111_1110;
   localparam logic [7:0] CMD_READ_SET  = 8'b1000_0001;

   localparam logic [2:0] CSR_HALF_ADDR  = 3'd0;
   localparam logic [2:0] CSR_GUARD_ADDR = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_GUARD_ON,
      PH_SEND_LOW,
      PH_SEND_HIGH,
      PH_RECV_HIGH,
      PH_RECV_LOW,
      PH_GUARD_OFF
   } phase_type;

   typedef struct packed {
      logic       io_in;
      logic [7:0] write_data;
      logic [7:0] command_byte;
      logic [1:0] operation;
   } req_item_type;

   typedef struct packed {
      logic       rejected;
      logic [7:0] read_result;
      logic       done_res;
      logic       busy_res;
      logic       io_drive;
      logic       io_out;
      logic       serial_clk;
      logic       chip_en;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] half_period_ticks;
      logic [7:0] enable_guard_ticks;
   } cfg_type;

   typedef struct packed {
      logic drv;
      logic io;
      logic clk;
      logic en;
   } pins_type;

endpackage

### design/three_wire_serial_master_top.sv
// Path: an accepted tick waits in the input register, and its result is then held in the
// result register. Throughput: one tick per cycle while the result side does not stall;
// the sequencer state updates in one pass per tick.
// Backpressure on the result side stalls the input register and then the input channel.
// Synchronous active-high reset clears the sequencer to idle with all pins low, the
// data line released, and the timing registers to half period 1 and guard 4.
module three_wire_serial_master_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [1:0] operation, [9:2] command_byte, [17:10] write_data, [18] io_in, rest zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] chip_en, [1] serial_clk, [2] io_out, [3] io_drive, [4] busy_res,
   // [5] done_res, [13:6] read_result, [14] rejected, [15] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import twsm_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff, in_item_in;
   logic         in_valid_ff, in_valid_in;
   rsp_item_type result;
   logic [15:0]  rsp_data_ff, rsp_data_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         advance, req_fire;

   twsm_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .cfg        (cfg)
   );

   twsm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .cfg   (cfg),
      .result(result)
   );

   // A tick moves on when the result register is empty or being drained.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_item_in  = in_item_ff;
      in_valid_in = in_valid_ff && !advance;
      if (req_fire) begin
         in_item_in.operation    = req_tdata[1:0];
         in_item_in.command_byte = req_tdata[9:2];
         in_item_in.write_data   = req_tdata[17:10];
         in_item_in.io_in        = req_tdata[18];
         in_valid_in             = 1'b1;
      end
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (advance) begin
         rsp_data_in  = {1'b0, result};
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_item_ff  <= in_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

### design/twsm_csr.sv
module twsm_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready,
   output twsm_pkg::cfg_type    cfg
);
   import twsm_pkg::*;

   logic [7:0] half_ff, half_in;
   logic [7:0] guard_ff, guard_in;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Address bit 2 selects the register; the low bits are ignored.
   always_comb begin
      half_in  = half_ff;
      guard_in = guard_ff;
      if (wr_en) begin
         if (csr_paddr[2] == CSR_GUARD_ADDR[2]) begin
            guard_in = csr_pwdata[7:0];
         end else begin
            half_in = csr_pwdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff  <= 8'd1;
         guard_ff <= 8'd4;
      end else begin
         half_ff  <= half_in;
         guard_ff <= guard_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == CSR_GUARD_ADDR[2]) ? {24'd0, guard_ff}
                                                           : {24'd0, half_ff};
   assign cfg.half_period_ticks  = half_ff;
   assign cfg.enable_guard_ticks = guard_ff;

endmodule

### design/twsm_seq.sv
module twsm_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  twsm_pkg::req_item_type item,
   input  twsm_pkg::cfg_type      cfg,
   output twsm_pkg::rsp_item_type result
);
   import twsm_pkg::*;

   phase_type             phase_ff, phase_in;
   logic [IDX_BITS-1:0]   bit_ff, bit_in, bit_inc;
   logic [7:0]            shift_ff, shift_in, shift_sel, shift_rx;
   logic [7:0]            pend_ff, pend_in;
   logic                  read_ff, read_in;
   logic [7:0]            wait_ff, wait_in, wait_dec;
   pins_type              pins_ff, pins_in;
   logic [7:0]            recv_ff, recv_in;
   logic [7:0]            half_len, guard_len;
   logic                  start, rej, done;

   assign half_len  = (cfg.half_period_ticks == 8'd0) ? 8'd1 : cfg.half_period_ticks;
   assign guard_len = (cfg.enable_guard_ticks == 8'd0) ? 8'd1 : cfg.enable_guard_ticks;
   assign start     = (item.operation == OP_WRITE) || (item.operation == OP_READ);
   assign bit_inc   = bit_ff + 1'b1;
   assign wait_dec  = (wait_ff != 8'd0) ? wait_ff - 8'd1 : 8'd0;
   assign shift_sel = (bit_inc == IDX_BITS'(BYTE_BITS)) ? pend_ff : shift_ff;
   assign shift_rx  = shift_ff | (8'(item.io_in) << bit_ff[2:0]);

   always_comb begin
      phase_in = phase_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pend_in  = pend_ff;
      read_in  = read_ff;
      wait_in  = wait_ff;
      pins_in  = pins_ff;
      recv_in  = recv_ff;
      rej      = 1'b0;
      done     = 1'b0;
      if (phase_ff == PH_IDLE) begin
         if (start) begin
            read_in  = (item.operation == OP_READ);
            shift_in = read_in ? (item.command_byte | CMD_READ_SET)
                               : ((item.command_byte | CMD_WRITE_SET) & CMD_WRITE_CLR);
            pend_in  = item.write_data;
            bit_in   = '0;
            pins_in  = '{drv: 1'b1, io: 1'b0, clk: 1'b0, en: 1'b1};
            phase_in = PH_GUARD_ON;
            wait_in  = guard_len;
         end
      end else begin
         rej     = start;
         wait_in = wait_dec;
         if (wait_dec == 8'd0) begin
            unique case (phase_ff)
               PH_GUARD_ON: begin
                  pins_in  = '{drv: 1'b1, io: shift_ff[bit_ff[2:0]], clk: 1'b0,
                               en: pins_ff.en};
                  phase_in = PH_SEND_LOW;
                  wait_in  = half_len;
               end
               PH_SEND_LOW: begin
                  pins_in.clk = 1'b1;
                  phase_in    = PH_SEND_HIGH;
                  wait_in     = half_len;
               end
               PH_SEND_HIGH: begin
                  bit_in = bit_inc;
                  if (read_ff && bit_inc == IDX_BITS'(BYTE_BITS)) begin
                     pins_in  = '{drv: 1'b0, io: 1'b0, clk: 1'b1, en: 1'b1};
                     bit_in   = '0;
                     shift_in = '0;
                     phase_in = PH_RECV_HIGH;
                     wait_in  = half_len;
                  end else if (!read_ff && bit_inc == '0) begin
                     pins_in  = '0;
                     phase_in = PH_GUARD_OFF;
                     wait_in  = guard_len;
                  end else begin
                     // The data byte follows the command byte on a write.
                     shift_in = shift_sel;
                     pins_in  = '{drv: 1'b1, io: shift_sel[bit_inc[2:0]], clk: 1'b0,
                                  en: pins_ff.en};
                     phase_in = PH_SEND_LOW;
                     wait_in  = half_len;
                  end
               end
               PH_RECV_HIGH: begin
                  pins_in  = '{drv: 1'b0, io: 1'b0, clk: 1'b0, en: 1'b1};
                  phase_in = PH_RECV_LOW;
                  wait_in  = half_len;
               end
               PH_RECV_LOW: begin
                  shift_in = shift_rx;
                  bit_in   = bit_inc;
                  if (bit_inc[IDX_BITS-1]) begin
                     recv_in  = shift_rx;
                     pins_in  = '0;
                     phase_in = PH_GUARD_OFF;
                     wait_in  = guard_len;
                  end else begin
                     pins_in  = '{drv: 1'b0, io: 1'b0, clk: 1'b1, en: 1'b1};
                     phase_in = PH_RECV_HIGH;
                     wait_in  = half_len;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  pins_in  = '0;
                  done     = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         bit_ff   <= '0;
         shift_ff <= '0;
         pend_ff  <= '0;
         read_ff  <= 1'b0;
         wait_ff  <= '0;
         pins_ff  <= '0;
         recv_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         pend_ff  <= pend_in;
         read_ff  <= read_in;
         wait_ff  <= wait_in;
         pins_ff  <= pins_in;
         recv_ff  <= recv_in;
      end
   end

   assign result.chip_en     = pins_in.en;
   assign result.serial_clk  = pins_in.clk;
   assign result.io_out      = pins_in.drv & pins_in.io;
   assign result.io_drive    = pins_in.drv;
   assign result.busy_res    = (phase_in != PH_IDLE);
   assign result.done_res    = done;
   assign result.read_result = recv_in;
   assign result.rejected    = rej;

   a_idle_pins_low: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> pins_ff == '0)
      else $error("pins active while idle");

   a_wait_loaded: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> wait_ff != 8'd0)
      else $error("wait count empty in an active phase");

   a_done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      step && done |=> phase_ff == PH_IDLE)
      else $error("transfer finished but sequencer not idle");

   a_read_released: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_RECV_HIGH || phase_ff == PH_RECV_LOW) |-> !pins_ff.drv)
      else $error("data line driven while receiving");

endmodule

### sim/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import twsm_pkg::*;

   // Operation code 3 is not defined by the block and must behave as a plain tick.
   localparam logic [1:0] OP_SPARE = 2'd3;

   localparam int HOLD_CYCLES  = 80;
   localparam int LONG_HOLD_AT = 400;
   localparam int STALL_LIMIT  = 2000;

   localparam rsp_item_type RSP_QUIET = '0;
   localparam rsp_item_type RSP_OPENING = '{rejected: 1'b0, read_result: 8'h00,
      done_res: 1'b0, busy_res: 1'b1, io_drive: 1'b1, io_out: 1'b0, serial_clk: 1'b0,
      chip_en: 1'b1};
   localparam rsp_item_type RSP_OPENING_REJECT = '{rejected: 1'b1, read_result: 8'h00,
      done_res: 1'b0, busy_res: 1'b1, io_drive: 1'b1, io_out: 1'b0, serial_clk: 1'b0,
      chip_en: 1'b1};

   typedef struct {
      logic [1:0]   op;
      logic [7:0]   cmd;
      logic [7:0]   wdata;
      logic         io;
      int           count;
      bit           typed;
      rsp_item_type want;
   } script_row_type;

   localparam int SCRIPT_ROWS = 11;
   script_row_type script [SCRIPT_ROWS] = '{
      '{OP_TICK,  8'h00, 8'h00, 1'b0,  1, 1'b1, RSP_QUIET},
      '{OP_SPARE, 8'hFF, 8'hFF, 1'b1,  1, 1'b1, RSP_QUIET},
      '{OP_WRITE, 8'hFF, 8'h00, 1'b0,  1, 1'b1, RSP_OPENING},
      '{OP_WRITE, 8'h00, 8'hFF, 1'b1,  1, 1'b1, RSP_OPENING_REJECT},
      // Read requests through the rest of the write; the last one lands on the
      // closing tick and is refused as well.
      '{OP_READ,  8'h00, 8'h00, 1'b0, 39, 1'b0, RSP_QUIET},
      '{OP_READ,  8'h00, 8'hFF, 1'b1,  1, 1'b1, RSP_OPENING},
      '{OP_SPARE, 8'h00, 8'h00, 1'b1, 48, 1'b0, RSP_QUIET},
      '{OP_READ,  8'h7E, 8'h00, 1'b0,  1, 1'b0, RSP_QUIET},
      '{OP_TICK,  8'h00, 8'h00, 1'b0, 48, 1'b0, RSP_QUIET},
      '{OP_WRITE, 8'h00, 8'hFF, 1'b1,  1, 1'b0, RSP_QUIET},
      '{OP_TICK,  8'h55, 8'hAA, 1'b1, 48, 1'b0, RSP_QUIET}
   };

   localparam int PHASES = 9;
   logic [7:0]  phase_half  [PHASES] = '{8'd0, 8'd1, 8'd2, 8'd7, 8'd1, 8'd5, 8'd1, 8'd3,
                                         8'd1};
   logic [7:0]  phase_guard [PHASES] = '{8'd0, 8'd1, 8'd3, 8'd2, 8'd255, 8'd1, 8'd2, 8'd5,
                                         8'd4};
   int unsigned phase_items [PHASES] = '{120, 120, 120, 100, 6, 6, 60, 100, 140};

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   three_wire_serial_master_top u_dut (.*);

   // Model of the bus sequencer, advanced once per accepted tick.
   phase_type  seq_phase;
   logic [3:0] seq_bit;
   logic [7:0] seq_shift;
   logic [7:0] seq_data;
   logic [7:0] seq_wait;
   logic [7:0] seq_rx;
   logic       seq_read;
   pins_type   seq_pins;
   logic [7:0] half_ticks;
   logic [7:0] guard_ticks;

   rsp_item_type tick_results_due [$];
   int           mismatch_count;
   int           results_seen;
   int           stall_cycles;
   bit           req_burst;

   function automatic logic [7:0] half_wait();
      return (half_ticks == 0) ? 8'd1 : half_ticks;
   endfunction

   function automatic logic [7:0] guard_wait();
      return (guard_ticks == 0) ? 8'd1 : guard_ticks;
   endfunction

   task automatic shift_bit();
      seq_pins  = '{drv: 1'b1, io: seq_shift[seq_bit[2:0]], clk: 1'b0, en: seq_pins.en};
      seq_phase = PH_SEND_LOW;
      seq_wait  = half_wait();
   endtask

   task automatic close_transfer();
      seq_pins  = '0;
      seq_phase = PH_GUARD_OFF;
      seq_wait  = guard_wait();
   endtask

   task automatic predict_bus_tick(input req_item_type item, output rsp_item_type pins);
      logic start;
      logic rej;
      logic done;
      start = (item.operation == OP_WRITE) || (item.operation == OP_READ);
      rej   = 1'b0;
      done  = 1'b0;
      if (seq_phase == PH_IDLE) begin
         if (start) begin
            seq_read  = (item.operation == OP_READ);
            seq_shift = seq_read ? (item.command_byte | CMD_READ_SET)
                                 : ((item.command_byte | CMD_WRITE_SET) & CMD_WRITE_CLR);
            seq_data  = item.write_data;
            seq_bit   = '0;
            seq_pins  = '{drv: 1'b1, io: 1'b0, clk: 1'b0, en: 1'b1};
            seq_phase = PH_GUARD_ON;
            seq_wait  = guard_wait();
         end
      end else begin
         rej = start;
         if (seq_wait != 0) seq_wait--;
         if (seq_wait == 0) begin
            case (seq_phase)
               PH_GUARD_ON: shift_bit();
               PH_SEND_LOW: begin
                  seq_pins.clk = 1'b1;
                  seq_phase    = PH_SEND_HIGH;
                  seq_wait     = half_wait();
               end
               PH_SEND_HIGH: begin
                  seq_bit++;
                  if (seq_read && seq_bit == BYTE_BITS) begin
                     // Command is out: release the line and start clocking data in.
                     seq_pins  = '{drv: 1'b0, io: 1'b0, clk: 1'b1, en: 1'b1};
                     seq_bit   = '0;
                     seq_shift = '0;
                     seq_phase = PH_RECV_HIGH;
                     seq_wait  = half_wait();
                  end else if (!seq_read && seq_bit == 0) begin
                     close_transfer();
                  end else begin
                     if (seq_bit == BYTE_BITS) seq_shift = seq_data;
                     shift_bit();
                  end
               end
               PH_RECV_HIGH: begin
                  seq_pins  = '{drv: 1'b0, io: 1'b0, clk: 1'b0, en: 1'b1};
                  seq_phase = PH_RECV_LOW;
                  seq_wait  = half_wait();
               end
               PH_RECV_LOW: begin
                  if (item.io_in) seq_shift[seq_bit[2:0]] = 1'b1;
                  seq_bit++;
                  if (seq_bit >= BYTE_BITS) begin
                     seq_rx = seq_shift;
                     close_transfer();
                  end else begin
                     seq_pins  = '{drv: 1'b0, io: 1'b0, clk: 1'b1, en: 1'b1};
                     seq_phase = PH_RECV_HIGH;
                     seq_wait  = half_wait();
                  end
               end
               default: begin
                  seq_phase = PH_IDLE;
                  seq_pins  = '0;
                  done      = 1'b1;
               end
            endcase
         end
      end
      pins.chip_en     = seq_pins.en;
      pins.serial_clk  = seq_pins.clk;
      pins.io_out      = seq_pins.drv & seq_pins.io;
      pins.io_drive    = seq_pins.drv;
      pins.busy_res    = (seq_phase != PH_IDLE);
      pins.done_res    = done;
      pins.read_result = seq_rx;
      pins.rejected    = rej;
   endtask

   function automatic req_item_type random_item(input bit allow_start);
      req_item_type item;
      item.io_in        = 1'($urandom_range(0, 1));
      item.write_data   = 8'($urandom_range(0, 255));
      item.command_byte = 8'($urandom_range(0, 255));
      item.operation    = OP_TICK;
      if (allow_start) begin
         // Mostly start a transfer as soon as the bus is free, with some stray
         // commands and spare codes landing in the middle of a transfer.
         if (seq_phase == PH_IDLE && $urandom_range(0, 3) != 0) begin
            item.operation = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
         end else begin
            case ($urandom_range(0, 15))
               0: item.operation = OP_WRITE;
               1: item.operation = OP_READ;
               2: item.operation = OP_SPARE;
               default: item.operation = OP_TICK;
            endcase
         end
      end
      return item;
   endfunction

   task automatic send_tick(input req_item_type item, input bit typed,
                            input rsp_item_type want);
      int unsigned  gap;
      rsp_item_type predicted;
      if ($urandom_range(0, 31) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'(item);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_bus_tick(item, predicted);
      tick_results_due.push_back(typed ? want : predicted);
   endtask

   task automatic drain_ticks();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tick_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic quiesce();
      while (seq_phase != PH_IDLE) send_tick(random_item(1'b0), 1'b0, RSP_QUIET);
      drain_ticks();
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_cycle(input logic [2:0] addr, input logic [31:0] data,
                            input logic write, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic program_register(input logic [2:0] addr, input logic [7:0] value);
      logic [31:0] readback;
      csr_cycle(addr, 32'(value), 1'b1, readback);
      csr_cycle(addr, '0, 1'b0, readback);
      if (readback[7:0] !== value) begin
         $display("%0t: register at %0d expected %0d, got %0d", $time, addr, value,
                  readback[7:0]);
         mismatch_count++;
      end
   endtask

   task automatic set_timing(input logic [7:0] half, input logic [7:0] guard);
      quiesce();
      program_register(CSR_HALF_ADDR, half);
      program_register(CSR_GUARD_ADDR, guard);
      half_ticks  = half;
      guard_ticks = guard;
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(rsp_item_type)-1:0];
         results_seen++;
         if (tick_results_due.size() == 0) begin
            $display("%0t: unexpected result transfer, got %h", $time, got);
            mismatch_count++;
         end else begin
            want = tick_results_due.pop_front();
            check_field("chip_en", 8'(want.chip_en), 8'(got.chip_en));
            check_field("serial_clk", 8'(want.serial_clk), 8'(got.serial_clk));
            check_field("io_out", 8'(want.io_out), 8'(got.io_out));
            check_field("io_drive", 8'(want.io_drive), 8'(got.io_drive));
            check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            check_field("done_res", 8'(want.done_res), 8'(got.done_res));
            check_field("read_result", want.read_result, got.read_result);
            check_field("rejected", 8'(want.rejected), 8'(got.rejected));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Result side: random stalls per transfer, plus one long hold-off while the
   // input side keeps offering ticks, so the block backs up and stalls its input.
   initial begin
      int unsigned gap;
      bit          burst;
      bit          held;
      rsp_tready = 1'b0;
      burst      = 1'b0;
      held       = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if ($urandom_range(0, 31) == 0) burst = !burst;
         gap = burst ? 0 : $urandom_range(0, 6);
         if (!held && results_seen >= LONG_HOLD_AT) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin
      script_row_type row;
      req_item_type   item;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      mismatch_count = 0;
      results_seen   = 0;
      stall_cycles   = 0;
      req_burst      = 1'b0;
      seq_phase      = PH_IDLE;
      seq_bit        = '0;
      seq_shift      = '0;
      seq_data       = '0;
      seq_wait       = '0;
      seq_rx         = '0;
      seq_read       = 1'b0;
      seq_pins       = '0;
      half_ticks     = 8'd1;
      guard_ticks    = 8'd4;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++) begin
         row = script[r];
         item = '{io_in: row.io, write_data: row.wdata, command_byte: row.cmd,
                  operation: row.op};
         repeat (row.count) send_tick(item, row.typed, row.want);
      end

      for (int p = 0; p < PHASES; p++) begin
         set_timing(phase_half[p], phase_guard[p]);
         for (int n = 0; n < phase_items[p]; n++) begin
            if (p == 2 && n == phase_items[p] / 2) drain_ticks();
            send_tick(random_item(1'b1), 1'b0, RSP_QUIET);
         end
      end

      quiesce();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
